>>> src/dtlv_pkg.sv
// Shared types and constants for the DER TLV header parser.
// Used by dtlv_step and der_tlv_header_parser_unit; depends on nothing else.

package dtlv_pkg;

   localparam int MAX_LEN_BYTES = 4;
   localparam int LEN_CNT_W     = $clog2(MAX_LEN_BYTES + 1);

   localparam logic [7:0] TAG_BIT_STRING = 8'h03;
   localparam logic [4:0] TAG_LONG_FORM  = 5'h1f;
   localparam logic [2:0] MAX_UNUSED     = 3'd7;

   typedef enum logic [4:0] {
      PH_TAG      = 5'b00001,
      PH_LEN      = 5'b00010,
      PH_LENX     = 5'b00100,
      PH_BITFIRST = 5'b01000,
      PH_BITREST  = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_END   = 2'd1,
      ST_BAD   = 2'd2,
      ST_UNSUP = 2'd3
   } status_type;

   typedef struct packed {
      logic       func;
      logic [7:0] data_byte;
      logic       is_last_available;
   } item_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  tag;
      logic [30:0] length;
      logic [2:0]  header_len;
   } result_type;

   typedef struct packed {
      phase_type              phase;
      logic [7:0]             tag_held;
      logic [31:0]            length_acc;
      logic [LEN_CNT_W-1:0]   length_bytes_left;
      logic [2:0]             header_count;
      logic [30:0]            content_left;
      logic [2:0]             unused_bits;
   } state_type;

endpackage

>>> src/dtlv_step.sv
// Next-state and result logic of the parser for one byte transaction.
// Depends on dtlv_pkg.

module dtlv_step (
   input  dtlv_pkg::item_type   item,
   input  dtlv_pkg::state_type  cur,
   output dtlv_pkg::state_type  nxt,
   output logic                 emit,
   output dtlv_pkg::result_type result
);

   dtlv_pkg::status_type st;
   logic                 fin_hdr;
   logic                 fin_bits;
   logic [2:0]           bits_u;
   logic [7:0]           mask;
   logic [7:0]           b;
   logic                 last;
   logic [6:0]           n;

   always_comb begin
      nxt      = cur;
      emit     = 1'b0;
      st       = dtlv_pkg::ST_OK;
      fin_hdr  = 1'b0;
      fin_bits = 1'b0;
      bits_u   = '0;
      b        = item.data_byte;
      last     = item.is_last_available;
      n        = b[6:0];
      mask     = '0;

      if (!item.func) begin
         emit = 1'b1;
         if (cur.phase == dtlv_pkg::PH_TAG) begin
            st               = dtlv_pkg::ST_END;
            nxt.tag_held     = '0;
            nxt.header_count = '0;
         end else begin
            st = dtlv_pkg::ST_BAD;
         end
      end else begin
         unique case (cur.phase)
            dtlv_pkg::PH_TAG: begin
               nxt.tag_held     = b;
               nxt.header_count = 3'd1;
               nxt.length_acc   = '0;
               if (last) begin
                  emit = 1'b1;
                  st   = dtlv_pkg::ST_BAD;
               end else if (b[4:0] == dtlv_pkg::TAG_LONG_FORM) begin
                  emit = 1'b1;
                  st   = dtlv_pkg::ST_UNSUP;
               end else begin
                  nxt.phase = dtlv_pkg::PH_LEN;
               end
            end
            dtlv_pkg::PH_LEN: begin
               nxt.header_count = 3'd2;
               if (b[7]) begin
                  if (n == '0) begin
                     emit = 1'b1;
                     st   = dtlv_pkg::ST_BAD;
                  end else if (last) begin
                     emit = 1'b1;
                     st   = dtlv_pkg::ST_BAD;
                  end else if (n > 7'(dtlv_pkg::MAX_LEN_BYTES)) begin
                     emit = 1'b1;
                     st   = dtlv_pkg::ST_UNSUP;
                  end else begin
                     nxt.length_bytes_left = n[dtlv_pkg::LEN_CNT_W-1:0];
                     nxt.length_acc        = '0;
                     nxt.phase             = dtlv_pkg::PH_LENX;
                  end
               end else begin
                  nxt.length_acc = {24'd0, b};
                  fin_hdr        = 1'b1;
               end
            end
            dtlv_pkg::PH_LENX: begin
               nxt.length_acc        = {cur.length_acc[23:0], b};
               nxt.length_acc[31]    = cur.length_acc[23] | (|cur.length_acc[31:23]);
               nxt.header_count      = cur.header_count + 3'd1;
               nxt.length_bytes_left = cur.length_bytes_left - dtlv_pkg::LEN_CNT_W'(1);
               if (nxt.length_bytes_left == '0) begin
                  fin_hdr = 1'b1;
               end else if (last) begin
                  emit = 1'b1;
                  st   = dtlv_pkg::ST_BAD;
               end
            end
            dtlv_pkg::PH_BITFIRST: begin
               if (b > {5'd0, dtlv_pkg::MAX_UNUSED}) begin
                  emit = 1'b1;
                  st   = dtlv_pkg::ST_BAD;
               end else begin
                  nxt.unused_bits  = b[2:0];
                  nxt.content_left = cur.content_left - 31'd1;
                  if (nxt.content_left == '0) begin
                     fin_bits = 1'b1;
                     bits_u   = b[2:0];
                  end else if (last) begin
                     emit = 1'b1;
                     st   = dtlv_pkg::ST_BAD;
                  end else begin
                     nxt.phase = dtlv_pkg::PH_BITREST;
                  end
               end
            end
            dtlv_pkg::PH_BITREST: begin
               nxt.content_left = cur.content_left - 31'd1;
               if (nxt.content_left == '0) begin
                  fin_bits = 1'b1;
                  bits_u   = cur.unused_bits;
               end else if (last) begin
                  emit = 1'b1;
                  st   = dtlv_pkg::ST_BAD;
               end
            end
            default: begin
               nxt.phase = dtlv_pkg::PH_TAG;
            end
         endcase
      end

      if (fin_hdr) begin
         if (nxt.length_acc[31]) begin
            emit = 1'b1;
            st   = dtlv_pkg::ST_UNSUP;
         end else if (nxt.tag_held == dtlv_pkg::TAG_BIT_STRING) begin
            if (nxt.length_acc == '0 || last) begin
               emit = 1'b1;
               st   = dtlv_pkg::ST_BAD;
            end else begin
               nxt.content_left = nxt.length_acc[30:0];
               nxt.phase        = dtlv_pkg::PH_BITFIRST;
            end
         end else begin
            emit = 1'b1;
            st   = dtlv_pkg::ST_OK;
         end
      end

      if (fin_bits) begin
         mask = ~(8'hff << bits_u);
         emit = 1'b1;
         st   = ((b & mask) != '0) ? dtlv_pkg::ST_BAD : dtlv_pkg::ST_OK;
      end

      result.status     = st;
      result.tag        = nxt.tag_held;
      result.length     = (st == dtlv_pkg::ST_OK) ? nxt.length_acc[30:0] : '0;
      result.header_len = nxt.header_count;
      if (emit) begin
         nxt.phase = dtlv_pkg::PH_TAG;
      end
   end

endmodule

>>> src/der_tlv_header_parser_unit.sv
// Top level of the DER TLV header parser: input register, parser state and result register.
// Depends on dtlv_pkg and dtlv_step.

// The unit takes one byte of a DER encoding per transaction and returns at most one
// result per transaction: status, tag, content length and header length of one element.
// It accepts a transaction in every cycle except for the stall below. The parser state is
// updated by a single pass of the step logic between the input register and the result
// register; a result appears once the byte that ends it has passed both. A result waiting on
// rsp_tready stalls the input only when the next byte would produce a result of its own.

module der_tlv_header_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // func
   input  logic        req_tlast,   // is_last_available
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // tag [7:0], length [38:8], header_len [41:39], zero
   output logic [1:0]  rsp_tuser    // status
);

   logic                 in_valid_ff;
   logic                 in_valid_in;
   dtlv_pkg::item_type   in_item_ff;
   dtlv_pkg::state_type  state_ff;
   dtlv_pkg::state_type  state_in;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   dtlv_pkg::result_type out_res_ff;
   dtlv_pkg::result_type step_res;
   logic                 step_emit;
   logic                 advance;

   dtlv_step u_step (
      .item   (in_item_ff),
      .cur    (state_ff),
      .nxt    (state_in),
      .emit   (step_emit),
      .result (step_res)
   );

   assign advance      = in_valid_ff && (!step_emit || !out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = (advance && step_emit) || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                <= 1'b0;
         out_valid_ff               <= 1'b0;
         state_ff.phase             <= dtlv_pkg::PH_TAG;
         state_ff.tag_held          <= '0;
         state_ff.length_acc        <= '0;
         state_ff.length_bytes_left <= '0;
         state_ff.header_count      <= '0;
         state_ff.content_left      <= '0;
         state_ff.unused_bits       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.func              <= req_tuser;
         in_item_ff.data_byte         <= req_tdata;
         in_item_ff.is_last_available <= req_tlast;
      end
      if (advance && step_emit) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_res_ff.status;
   assign rsp_tdata  = {6'd0, out_res_ff.header_len, out_res_ff.length, out_res_ff.tag};

endmodule
